/* rtl/core/lac_pkg.sv */
package lac_pkg;

  localparam int ENTRIES   = 16;
  localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int LEAVES    = 1 << IDX_W;
  localparam int FILL_W    = $clog2(ENTRIES + 1);
  localparam int CUT       = IDX_W / 2;
  localparam int MID_N     = 1 << CUT;

  localparam int CFG_W     = 5;
  localparam int ADDR_W    = 32;
  localparam int STAMP_W   = 32;
  localparam int CNT_W     = 32;
  localparam int SLOT_W    = 4;
  localparam int OUTCOME_W = 2;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd16;

  localparam logic [OUTCOME_W-1:0] OUT_HIT     = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_FILL    = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_REPLACE = 2'd2;

  typedef struct packed {
    logic load;
    logic capture;
    logic commit;
  } lac_cmd_t;

  typedef struct packed {
    logic               valid;
    logic [STAMP_W-1:0] stamp;
    logic [IDX_W-1:0]   idx;
  } lac_node_t;

  // Older of two candidates; on equal stamps the left (lower index) one wins.
  function automatic lac_node_t min_node(lac_node_t a, lac_node_t b);
    lac_node_t r;
    if (a.valid && (!b.valid || a.stamp <= b.stamp)) begin
      r = a;
    end else begin
      r = b;
    end
    return r;
  endfunction

endpackage

/* rtl/core/lac_ctrl.sv */
module lac_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output lac_pkg::lac_cmd_t cmd
);
  import lac_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    SEARCH,
    UPDATE
  } state_t;

  state_t state;
  logic   out_free;
  logic   accept;

  assign out_free    = !out_valid || !out_stall;
  assign cmd.commit  = (state == UPDATE) && out_free;
  assign in_stall    = !((state == IDLE) || cmd.commit);
  assign accept      = in_valid && !in_stall;
  assign cmd.load    = accept;
  assign cmd.capture = (state == SEARCH);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (accept) begin
            state <= SEARCH;
          end
        end
        SEARCH: begin
          state <= UPDATE;
        end
        UPDATE: begin
          if (cmd.commit) begin
            state <= accept ? SEARCH : IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* rtl/core/lac_dp.sv */
module lac_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  lac_pkg::lac_cmd_t               cmd,
  input  logic                            cfg_write_en,
  input  logic [lac_pkg::CFG_W-1:0]       cfg_write_data,
  input  logic [lac_pkg::ADDR_W-1:0]      lookup_addr,
  output logic [lac_pkg::OUTCOME_W-1:0]   outcome,
  output logic [lac_pkg::SLOT_W-1:0]      slot,
  output logic [lac_pkg::CNT_W-1:0]       hit_total,
  output logic [lac_pkg::CNT_W-1:0]       lookup_total
);
  import lac_pkg::*;

  localparam int LIM_W = (FILL_W > CFG_W) ? FILL_W : CFG_W;

  logic [ADDR_W-1:0]  entry_address [ENTRIES];
  logic [STAMP_W-1:0] entry_stamp   [ENTRIES];

  logic [CFG_W-1:0]   active_entries;
  logic [FILL_W-1:0]  filled_count;
  logic [STAMP_W-1:0] use_stamp;
  logic [CNT_W-1:0]   hit_counter;
  logic [CNT_W-1:0]   lookup_counter;

  logic [ADDR_W-1:0]  req_addr;
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] match_next;
  lac_node_t          mid [MID_N];

  lac_node_t          tree1 [1:2*LEAVES-1];
  lac_node_t          tree2 [1:2*MID_N-1];

  logic               hit;
  logic [IDX_W-1:0]   hit_idx;
  logic [LIM_W-1:0]   act_ext;
  logic [LIM_W-1:0]   lim;
  logic               fill_ok;
  logic [IDX_W-1:0]   slot_sel;
  logic [STAMP_W-1:0] stamp_next;
  logic [OUTCOME_W-1:0] outcome_next;

  // Search cycle: compare lanes and the lower half of the minimum tree.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      tree1[LEAVES+i].valid = FILL_W'(i) < filled_count;
      tree1[LEAVES+i].stamp = entry_stamp[i];
      tree1[LEAVES+i].idx   = IDX_W'(i);
      match_next[i] = (FILL_W'(i) < filled_count) && (entry_address[i] == req_addr);
    end
    for (int i = ENTRIES; i < LEAVES; i++) begin
      tree1[LEAVES+i] = '0;
    end
    for (int k = LEAVES - 1; k >= 1; k--) begin
      if (k >= MID_N) begin
        tree1[k] = min_node(tree1[2*k], tree1[2*k+1]);
      end else begin
        tree1[k] = '0;
      end
    end
  end

  // Update cycle: upper half of the tree, hit priority and slot choice.
  always_comb begin
    for (int j = 0; j < MID_N; j++) begin
      tree2[MID_N+j] = mid[j];
    end
    for (int k = MID_N - 1; k >= 1; k--) begin
      tree2[k] = min_node(tree2[2*k], tree2[2*k+1]);
    end
    hit_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign hit        = |match;
  assign act_ext    = LIM_W'(active_entries);
  assign lim        = (act_ext == '0) ? LIM_W'(1) :
                      ((act_ext > LIM_W'(ENTRIES)) ? LIM_W'(ENTRIES) : act_ext);
  assign fill_ok    = LIM_W'(filled_count) < lim;
  assign stamp_next = use_stamp + STAMP_W'(1);

  always_comb begin
    if (hit) begin
      slot_sel     = hit_idx;
      outcome_next = OUT_HIT;
    end else if (fill_ok) begin
      slot_sel     = IDX_W'(filled_count);
      outcome_next = OUT_FILL;
    end else begin
      slot_sel     = tree2[1].idx;
      outcome_next = OUT_REPLACE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_entries <= ACTIVE_RESET;
      filled_count   <= '0;
      use_stamp      <= '0;
      hit_counter    <= '0;
      lookup_counter <= '0;
    end else begin
      if (cfg_write_en) begin
        active_entries <= cfg_write_data;
      end
      if (cmd.commit) begin
        use_stamp      <= stamp_next;
        lookup_counter <= lookup_counter + CNT_W'(1);
        if (hit) begin
          hit_counter <= hit_counter + CNT_W'(1);
        end else if (fill_ok) begin
          filled_count <= filled_count + FILL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_addr <= lookup_addr;
    end
    if (cmd.capture) begin
      match <= match_next;
      for (int j = 0; j < MID_N; j++) begin
        mid[j] <= tree1[MID_N+j];
      end
    end
    if (cmd.commit) begin
      entry_stamp[slot_sel] <= stamp_next;
      if (!hit) begin
        entry_address[slot_sel] <= req_addr;
      end
      outcome      <= outcome_next;
      slot         <= SLOT_W'(slot_sel);
      hit_total    <= hit ? hit_counter + CNT_W'(1) : hit_counter;
      lookup_total <= lookup_counter + CNT_W'(1);
    end
  end

endmodule

/* rtl/core/lru_address_cache.sv */
// Channel   Direction  Handshake             Word
// input     in         in_valid / in_stall   lookup_addr
// result    out        out_valid / out_stall outcome, slot, hit_total, lookup_total
// config    in         cfg_write_en          cfg_write_data (active_entries)
//
// Each word passes through a search cycle that runs the sixteen address
// compares and the lower half of the minimum-stamp tree, and then an update
// cycle that finishes the tree and writes the chosen entry. While a word is
// in flight, a new one is taken only in the update cycle that commits its result.
// Reset is synchronous; entries are not cleared, the fill count masks them.
// A stalled result holds the update cycle until the output register frees.
module lru_address_cache (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [lac_pkg::CFG_W-1:0]     cfg_write_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [lac_pkg::ADDR_W-1:0]    lookup_addr,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [lac_pkg::OUTCOME_W-1:0] outcome,
  output logic [lac_pkg::SLOT_W-1:0]    slot,
  output logic [lac_pkg::CNT_W-1:0]     hit_total,
  output logic [lac_pkg::CNT_W-1:0]     lookup_total
);
  import lac_pkg::*;

  lac_cmd_t cmd;

  lac_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  lac_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .lookup_addr    (lookup_addr),
    .outcome        (outcome),
    .slot           (slot),
    .hit_total      (hit_total),
    .lookup_total   (lookup_total)
  );

  // A committed lookup always leaves a result waiting.
  assert property (@(posedge clk) disable iff (rst) cmd.commit |=> out_valid)
    else $error("commit did not present a result");

  // A word just taken is still searching in the next cycle.
  assert property (@(posedge clk) disable iff (rst) cmd.load |=> (in_stall && !cmd.commit))
    else $error("word accepted during search cycle");

  // Only the three defined outcomes are ever presented.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (outcome == OUT_HIT || outcome == OUT_FILL || outcome == OUT_REPLACE))
    else $error("undefined outcome code");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import lac_pkg::*;

  localparam int POOL_SIZE         = 24;
  localparam int WORDS_PER_SEGMENT = 150;
  localparam int HOLD_AT_WORD      = 1000;
  localparam int HOLD_CYCLES       = 96;
  localparam int REPORT_LINES      = 40;
  localparam int DIRECTED_ROWS     = 24;

  typedef enum logic {ROW_LOOKUP, ROW_CONFIG} row_kind_t;

  typedef struct packed {
    logic [OUTCOME_W-1:0] outcome;
    logic [SLOT_W-1:0]    slot;
    logic [CNT_W-1:0]     hit_total;
    logic [CNT_W-1:0]     lookup_total;
  } lookup_result_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [ADDR_W-1:0]    value;
    logic                 typed;
    logic [OUTCOME_W-1:0] outcome;
    logic [SLOT_W-1:0]    slot;
  } stim_row_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write_en;
  logic [CFG_W-1:0]     cfg_write_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [ADDR_W-1:0]    lookup_addr;
  logic                 out_valid;
  logic                 out_stall;
  logic [OUTCOME_W-1:0] outcome;
  logic [SLOT_W-1:0]    slot;
  logic [CNT_W-1:0]     hit_total;
  logic [CNT_W-1:0]     lookup_total;

  // Shadow copy of the cache contents and counters.
  logic [ADDR_W-1:0]  cached_addr [ENTRIES];
  logic [STAMP_W-1:0] cached_stamp [ENTRIES];
  int unsigned        fill_count   = 0;
  logic [STAMP_W-1:0] use_clock    = '0;
  logic [CNT_W-1:0]   hits_seen    = '0;
  logic [CNT_W-1:0]   lookups_seen = '0;
  logic [CFG_W-1:0]   active_limit = ACTIVE_RESET;

  lookup_result_t    pending_results [$];
  logic [ADDR_W-1:0] address_pool [POOL_SIZE];
  int                mismatch_count = 0;
  int                words_sent     = 0;
  int                send_idle_pct  = 0;
  int                recv_stall_pct = 0;
  int                working_set;
  logic              long_hold;

  logic [CFG_W-1:0] limit_plan [9] = '{5'd3, 5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd8, 5'd2,
                                       5'd12};
  int send_idle_plan [3] = '{27, 84, 0};
  int recv_stall_plan [3] = '{84, 27, 0};

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_LOOKUP, 32'h0000_0000, 1'b1, OUT_FILL, 4'd0},
    '{ROW_LOOKUP, 32'hFFFF_FFFF, 1'b1, OUT_FILL, 4'd1},
    '{ROW_LOOKUP, 32'h0000_0000, 1'b1, OUT_HIT,  4'd0},
    '{ROW_LOOKUP, 32'hFFFF_FFFF, 1'b1, OUT_HIT,  4'd1},
    '{ROW_LOOKUP, 32'h0A00_0001, 1'b1, OUT_FILL, 4'd2},
    '{ROW_LOOKUP, 32'hAAAA_AAAA, 1'b1, OUT_FILL, 4'd3},
    '{ROW_LOOKUP, 32'h5555_5555, 1'b1, OUT_FILL, 4'd4},
    // Limit drops below the number of filled entries.
    '{ROW_CONFIG, 32'd2,         1'b0, OUT_HIT,  4'd0},
    '{ROW_LOOKUP, 32'h0A00_0002, 1'b0, OUT_HIT,  4'd0},
    '{ROW_LOOKUP, 32'h0000_0000, 1'b0, OUT_HIT,  4'd0},
    '{ROW_LOOKUP, 32'h0A00_0002, 1'b0, OUT_HIT,  4'd0},
    // A limit of zero behaves as one.
    '{ROW_CONFIG, 32'd0,         1'b0, OUT_HIT,  4'd0},
    '{ROW_LOOKUP, 32'h8000_0001, 1'b0, OUT_HIT,  4'd0},
    '{ROW_LOOKUP, 32'h8000_0001, 1'b0, OUT_HIT,  4'd0},
    // Limits above the entry count behave as the entry count.
    '{ROW_CONFIG, 32'd31,        1'b0, OUT_HIT,  4'd0},
    '{ROW_LOOKUP, 32'h7FFF_FFFF, 1'b0, OUT_HIT,  4'd0},
    '{ROW_LOOKUP, 32'h0102_0304, 1'b0, OUT_HIT,  4'd0},
    '{ROW_CONFIG, 32'd17,        1'b0, OUT_HIT,  4'd0},
    '{ROW_LOOKUP, 32'hC0A8_0101, 1'b0, OUT_HIT,  4'd0},
    '{ROW_LOOKUP, 32'h0102_0304, 1'b0, OUT_HIT,  4'd0},
    '{ROW_CONFIG, 32'd16,        1'b0, OUT_HIT,  4'd0},
    '{ROW_LOOKUP, 32'hFFFF_FFFE, 1'b0, OUT_HIT,  4'd0},
    '{ROW_LOOKUP, 32'h0000_0001, 1'b0, OUT_HIT,  4'd0},
    '{ROW_LOOKUP, 32'h0A00_0001, 1'b0, OUT_HIT,  4'd0}
  };

  lru_address_cache u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .lookup_addr    (lookup_addr),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .outcome        (outcome),
    .slot           (slot),
    .hit_total      (hit_total),
    .lookup_total   (lookup_total)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic lookup_result_t predict_lookup(input logic [ADDR_W-1:0] addr);
    lookup_result_t r;
    int unsigned    limit;
    int unsigned    pick;
    bit             found;
    found = 1'b0;
    pick = 0;
    use_clock = use_clock + STAMP_W'(1);
    lookups_seen = lookups_seen + CNT_W'(1);
    limit = (active_limit == 0) ? 1 : ((active_limit > ENTRIES) ? ENTRIES : 32'(active_limit));
    for (int unsigned i = 0; i < fill_count; i++) begin
      if (!found && cached_addr[i] == addr) begin
        found = 1'b1;
        pick = i;
      end
    end
    if (found) begin
      hits_seen = hits_seen + CNT_W'(1);
      r.outcome = OUT_HIT;
    end else if (fill_count < limit) begin
      pick = fill_count;
      fill_count++;
      r.outcome = OUT_FILL;
    end else begin
      // Oldest stamp wins; the first of equal stamps is kept.
      for (int unsigned i = 1; i < fill_count; i++) begin
        if (cached_stamp[i] < cached_stamp[pick]) begin
          pick = i;
        end
      end
      r.outcome = OUT_REPLACE;
    end
    cached_addr[pick] = addr;
    cached_stamp[pick] = use_clock;
    r.slot = pick[SLOT_W-1:0];
    r.hit_total = hits_seen;
    r.lookup_total = lookups_seen;
    return r;
  endfunction

  // Mostly draws from a working set so that hits and evictions both happen.
  function automatic logic [ADDR_W-1:0] pick_address(input int span);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      address_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom;
    end
    if (roll >= 85) begin
      return $urandom;
    end
    return address_pool[$urandom_range(0, span - 1)];
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LINES) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    end
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic offer_word(input logic [ADDR_W-1:0] addr, input logic typed,
                            input logic [OUTCOME_W-1:0] typed_outcome,
                            input logic [SLOT_W-1:0] typed_slot);
    lookup_result_t due;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      lookup_addr <= $urandom;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    lookup_addr <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    due = predict_lookup(addr);
    if (typed) begin
      due.outcome = typed_outcome;
      due.slot = typed_slot;
    end
    pending_results.push_back(due);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic write_active_entries(input logic [CFG_W-1:0] value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= value;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    active_limit = value;
  endtask

  always @(posedge clk) begin : result_check
    lookup_result_t due;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("word with nothing pending", '0, lookup_total);
      end else begin
        due = pending_results.pop_front();
        if (outcome !== due.outcome) report_mismatch("outcome", due.outcome, outcome);
        if (slot !== due.slot) report_mismatch("slot", due.slot, slot);
        if (hit_total !== due.hit_total) report_mismatch("hit_total", due.hit_total, hit_total);
        if (lookup_total !== due.lookup_total) begin
          report_mismatch("lookup_total", due.lookup_total, lookup_total);
        end
      end
    end
  end

  initial begin : result_sink
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= long_hold || ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // One long hold-off while the sender keeps offering, so the block backs up.
  initial begin : long_hold_ctl
    int held;
    long_hold = 1'b0;
    wait (words_sent >= HOLD_AT_WORD);
    @(negedge clk);
    long_hold <= 1'b1;
    for (held = 0; held < HOLD_CYCLES; held++) @(negedge clk);
    long_hold <= 1'b0;
  end

  initial begin
    #3000000;
    $display("[lru_address_cache] ERROR");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_write_en = 1'b0;
    cfg_write_data = '0;
    in_valid = 1'b0;
    lookup_addr = '0;
    address_pool[0] = 32'h0000_0000;
    address_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) address_pool[i] = $urandom;
    limit_plan[8] = CFG_W'($urandom_range(0, 31));
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (directed_rows[r].kind == ROW_CONFIG) begin
        write_active_entries(directed_rows[r].value[CFG_W-1:0]);
      end else begin
        offer_word(directed_rows[r].value, directed_rows[r].typed,
                   directed_rows[r].outcome, directed_rows[r].slot);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = send_idle_plan[ph];
      recv_stall_pct = recv_stall_plan[ph];
      for (int seg = 0; seg < 3; seg++) begin
        write_active_entries(limit_plan[ph * 3 + seg]);
        working_set = $urandom_range(2, POOL_SIZE);
        for (int n = 0; n < WORDS_PER_SEGMENT; n++) begin
          offer_word(pick_address(working_set), 1'b0, OUT_HIT, '0);
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("[lru_address_cache] OK");
    end else begin
      $display("[lru_address_cache] ERROR");
    end
    $finish;
  end

endmodule
